@@ src/infix_postfix_stack_machine_macros.svh @@
// Assertion macros shared by the files that carry checks.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef INFIX_POSTFIX_STACK_MACHINE_MACROS_SVH
`define INFIX_POSTFIX_STACK_MACHINE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define IPSM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define IPSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ipsm_pkg.sv @@
package ipsm_pkg;

  localparam int DATA_W    = 32;
  localparam int DIV_CNT_W = $clog2(DATA_W);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef logic [1:0] err_t;
  localparam err_t ERR_OK    = 2'd0;
  localparam err_t ERR_UNDER = 2'd1;
  localparam err_t ERR_DIVZ  = 2'd2;

  // Priority ranks; "no rank" is encoded lowest so unsigned compare works.
  typedef logic [1:0] rank_t;
  localparam rank_t RANK_NONE = 2'd0;
  localparam rank_t RANK_ADD  = 2'd1;
  localparam rank_t RANK_MUL  = 2'd2;

  typedef logic [2:0] opc_t;
  localparam opc_t OPC_ADD   = 3'd0;
  localparam opc_t OPC_SUB   = 3'd1;
  localparam opc_t OPC_MUL   = 3'd2;
  localparam opc_t OPC_DIV   = 3'd3;
  localparam opc_t OPC_OTHER = 3'd4;

  typedef logic [1:0] push_sel_t;
  localparam push_sel_t PUSH_CHAR  = 2'd0;
  localparam push_sel_t PUSH_DIGIT = 2'd1;
  localparam push_sel_t PUSH_RES   = 2'd2;

  typedef logic [1:0] emit_sel_t;
  localparam emit_sel_t EMIT_CHAR  = 2'd0;
  localparam emit_sel_t EMIT_STACK = 2'd1;
  localparam emit_sel_t EMIT_VALUE = 2'd2;
  localparam emit_sel_t EMIT_EMPTY = 2'd3;

  typedef struct packed {
    logic      load;
    logic      rd;
    logic      dec;
    logic      push;
    push_sel_t push_sel;
    logic      take_v1;
    logic      take_v2;
    logic      take_zero;
    logic      note_under;
    logic      note_divz;
    logic      alu;
    logic      div_start;
    logic      div_take;
    logic      emit;
    emit_sel_t emit_sel;
    logic      emit_last;
    logic      clear_end;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_one;
    logic digit;
    logic last;
    logic rank_pop;
    opc_t opc;
    logic v1_zero;
    logic out_free;
    logic div_done;
  } stat_t;

  function automatic rank_t rank_of(input logic [DATA_W-1:0] v);
    rank_t r;
    r = RANK_NONE;
    if (v == {24'd0, CH_PLUS} || v == {24'd0, CH_MINUS}) begin
      r = RANK_ADD;
    end else if (v == {24'd0, CH_STAR} || v == {24'd0, CH_SLASH}) begin
      r = RANK_MUL;
    end
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic opc_t op_class(input logic [7:0] c);
    opc_t o;
    o = OPC_OTHER;
    if (c == CH_PLUS) begin
      o = OPC_ADD;
    end else if (c == CH_MINUS) begin
      o = OPC_SUB;
    end else if (c == CH_STAR) begin
      o = OPC_MUL;
    end else if (c == CH_SLASH) begin
      o = OPC_DIV;
    end
    return o;
  endfunction

endpackage

@@ src/ipsm_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module ipsm_div import ipsm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DATA_W-1:0]    quo;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    dvs;
  logic [DATA_W:0]      rem_sh;
  logic [DATA_W:0]      diff;

  assign rem_sh   = {rem, quo[DATA_W-1]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(DATA_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ src/ipsm_dp.sv @@
// Datapath: shared stack memory, count, error flag, operand and result
// registers, the divider and the output register.
module ipsm_dp import ipsm_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [7:0]         in_char,
  input  logic               in_last,
  input  logic               out_stall,
  output stat_t              stat,
  output logic               out_valid,
  output logic [7:0]         out_char,
  output logic signed [31:0] value,
  output logic [1:0]         status,
  output logic               out_last
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_m1;
  err_t              err;
  logic [7:0]        char_q;
  logic              last_q;
  logic [DATA_W-1:0] v1;
  logic [DATA_W-1:0] v2;
  logic [DATA_W-1:0] res;
  logic              neg;
  logic [DATA_W-1:0] push_data;
  logic [DATA_W-1:0] prod;
  logic              full;
  logic              div_done;
  logic [DATA_W-1:0] div_q;
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;

  assign count_m1 = count - 1'b1;
  assign full     = (count >= CW'(STACK_DEPTH));
  assign prod     = v2 * v1;
  assign mag_a    = v2[DATA_W-1] ? (~v2 + 1'b1) : v2;
  assign mag_b    = v1[DATA_W-1] ? (~v1 + 1'b1) : v1;

  always_comb begin
    case (cmd.push_sel)
      PUSH_CHAR:  push_data = {24'd0, char_q};
      PUSH_DIGIT: push_data = {24'd0, char_q - CH_ZERO};
      default:    push_data = res;
    endcase
  end

  ipsm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mag_a),
    .divisor  (mag_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // Stack memory: one write port, one registered read port at the top entry.
  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[count[AW-1:0]] <= push_data;
    end
    if (cmd.rd) begin
      rd_data <= mem[count_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      err   <= ERR_OK;
    end else begin
      if (cmd.clear_end) begin
        count <= '0;
      end else if (cmd.dec) begin
        count <= count_m1;
      end else if (cmd.push && !full) begin
        count <= count + 1'b1;
      end
      if (cmd.clear_end) begin
        err <= ERR_OK;
      end else if (cmd.note_under && err == ERR_OK) begin
        err <= ERR_UNDER;
      end else if (cmd.note_divz && err == ERR_OK) begin
        err <= ERR_DIVZ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_q <= in_char;
      last_q <= in_last;
    end
    if (cmd.take_v1) begin
      v1 <= cmd.take_zero ? '0 : rd_data;
    end
    if (cmd.take_v2) begin
      v2 <= cmd.take_zero ? '0 : rd_data;
    end
    if (cmd.div_start) begin
      neg <= v2[DATA_W-1] ^ v1[DATA_W-1];
    end
    if (cmd.alu) begin
      case (op_class(char_q))
        OPC_ADD: res <= v2 + v1;
        OPC_SUB: res <= v2 - v1;
        OPC_MUL: res <= prod;
        default: res <= '0;
      endcase
    end else if (cmd.div_take) begin
      res <= neg ? (~div_q + 1'b1) : div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last <= cmd.emit_last;
      case (cmd.emit_sel)
        EMIT_CHAR: begin
          out_char <= char_q;
          value    <= '0;
          status   <= ERR_OK;
        end
        EMIT_STACK: begin
          out_char <= rd_data[7:0];
          value    <= '0;
          status   <= ERR_OK;
        end
        EMIT_VALUE: begin
          out_char <= '0;
          value    <= $signed(rd_data);
          status   <= err;
        end
        default: begin
          out_char <= '0;
          value    <= '0;
          status   <= (err == ERR_OK) ? ERR_UNDER : err;
        end
      endcase
    end
  end

  always_comb begin
    stat.count_zero = (count == '0);
    stat.count_one  = (count == CW'(1));
    stat.digit      = is_digit(char_q);
    stat.last       = last_q;
    stat.rank_pop   = (rank_of({24'd0, char_q}) <= rank_of(rd_data));
    stat.opc        = op_class(char_q);
    stat.v1_zero    = (v1 == '0);
    stat.out_free   = !out_valid || !out_stall;
    stat.div_done   = div_done;
  end

endmodule

@@ src/ipsm_ctrl.sv @@
// Sequencer: walks one character through its stack operations.
module ipsm_ctrl import ipsm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  mode,
  input  logic  in_valid,
  input  stat_t stat,
  output logic  in_stall,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_CMP_RD  = 4'd2;
  localparam logic [3:0] S_CMP     = 4'd3;
  localparam logic [3:0] S_CPUSH   = 4'd4;
  localparam logic [3:0] S_DRAIN   = 4'd5;
  localparam logic [3:0] S_DRAIN_W = 4'd6;
  localparam logic [3:0] S_POP1    = 4'd7;
  localparam logic [3:0] S_POP1_W  = 4'd8;
  localparam logic [3:0] S_POP2    = 4'd9;
  localparam logic [3:0] S_POP2_W  = 4'd10;
  localparam logic [3:0] S_OP      = 4'd11;
  localparam logic [3:0] S_DIV     = 4'd12;
  localparam logic [3:0] S_EPUSH   = 4'd13;
  localparam logic [3:0] S_RES     = 4'd14;
  localparam logic [3:0] S_RES_W   = 4'd15;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!mode) begin
          if (stat.digit) begin
            if (stat.out_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_sel  = EMIT_CHAR;
              cmd.emit_last = stat.last && stat.count_zero;
              state_next    = stat.last ? S_DRAIN : S_IDLE;
            end
          end else begin
            state_next = S_CMP_RD;
          end
        end else if (stat.digit) begin
          cmd.push     = 1'b1;
          cmd.push_sel = PUSH_DIGIT;
          state_next   = stat.last ? S_RES : S_IDLE;
        end else begin
          state_next = S_POP1;
        end
      end
      S_CMP_RD: begin
        if (stat.count_zero) begin
          state_next = S_CPUSH;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (!stat.rank_pop) begin
          state_next = S_CPUSH;
        end else if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_STACK;
          cmd.dec      = 1'b1;
          state_next   = S_CMP_RD;
        end
      end
      S_CPUSH: begin
        cmd.push     = 1'b1;
        cmd.push_sel = PUSH_CHAR;
        state_next   = stat.last ? S_DRAIN : S_IDLE;
      end
      S_DRAIN: begin
        if (stat.count_zero) begin
          cmd.clear_end = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_DRAIN_W;
        end
      end
      S_DRAIN_W: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EMIT_STACK;
          cmd.emit_last = stat.count_one;
          cmd.dec       = 1'b1;
          state_next    = S_DRAIN;
        end
      end
      S_POP1: begin
        if (stat.count_zero) begin
          cmd.take_v1    = 1'b1;
          cmd.take_zero  = 1'b1;
          cmd.note_under = 1'b1;
          state_next     = S_POP2;
        end else begin
          cmd.rd     = 1'b1;
          cmd.dec    = 1'b1;
          state_next = S_POP1_W;
        end
      end
      S_POP1_W: begin
        cmd.take_v1 = 1'b1;
        state_next  = S_POP2;
      end
      S_POP2: begin
        if (stat.count_zero) begin
          cmd.take_v2    = 1'b1;
          cmd.take_zero  = 1'b1;
          cmd.note_under = 1'b1;
          state_next     = S_OP;
        end else begin
          cmd.rd     = 1'b1;
          cmd.dec    = 1'b1;
          state_next = S_POP2_W;
        end
      end
      S_POP2_W: begin
        cmd.take_v2 = 1'b1;
        state_next  = S_OP;
      end
      S_OP: begin
        case (stat.opc) inside
          OPC_ADD, OPC_SUB, OPC_MUL: begin
            cmd.alu    = 1'b1;
            state_next = S_EPUSH;
          end
          OPC_DIV: begin
            if (stat.v1_zero) begin
              cmd.alu       = 1'b1;
              cmd.note_divz = 1'b1;
              state_next    = S_EPUSH;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = S_DIV;
            end
          end
          default: begin
            state_next = stat.last ? S_RES : S_IDLE;
          end
        endcase
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = S_EPUSH;
        end
      end
      S_EPUSH: begin
        cmd.push     = 1'b1;
        cmd.push_sel = PUSH_RES;
        state_next   = stat.last ? S_RES : S_IDLE;
      end
      S_RES: begin
        if (!stat.count_zero) begin
          cmd.rd     = 1'b1;
          state_next = S_RES_W;
        end else if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EMIT_EMPTY;
          cmd.emit_last = 1'b1;
          cmd.clear_end = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_RES_W: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EMIT_VALUE;
          cmd.emit_last = 1'b1;
          cmd.clear_end = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ src/infix_postfix_stack_machine.sv @@
// Infix-to-postfix converter and postfix evaluator sharing one operand stack.
// Characters arrive one per input transaction, with in_last on the final one.
// With mode at 0 the block runs the shunting-yard scheme and returns postfix
// characters on out_char; with mode at 1 it evaluates a postfix expression
// of single digits and returns one transaction at the end carrying value and
// status (0 ok, 1 stack underflow, 2 division by zero; the first error
// sticks). Stack and error are cleared after every last character. Items
// are processed one at a time; the stack sits in a memory with a registered
// read port, so each stack read is registered before its data is used. An
// evaluate-mode division runs on the one-bit-per-cycle 32-bit divider. A
// result waiting in the output register stalls the sequencer only when the
// next result is ready to be written. The mode register sits at byte
// address 0 of the configuration port and must be written only while the
// block is idle.
module infix_postfix_stack_machine import ipsm_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char,
  input  logic               in_last,
  // Output channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_char,
  output logic signed [31:0] value,
  output logic [1:0]         status,
  output logic               out_last
);

`include "infix_postfix_stack_machine_macros.svh"

  localparam logic [2:0] ADDR_MODE = 3'd0;

  logic  mode;
  cmd_t  cmd;
  stat_t stat;

  // The port never inserts wait states.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MODE) ? {31'd0, mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_MODE) begin
      mode <= pwdata[0];
    end
  end

  // The sequencer issues one command word per cycle; the datapath answers
  // with a status word describing the stack top, the count and the output.
  ipsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .mode     (mode),
    .in_valid (in_valid),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  ipsm_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_char   (in_char),
    .in_last   (in_last),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_char  (out_char),
    .value     (value),
    .status    (status),
    .out_last  (out_last)
  );

  // One character is worked on at a time.
  `IPSM_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "second item taken while busy")
  // A new result is written only when the previous one has gone or is leaving.
  `IPSM_ASSERT_SAME(a_no_overwrite, cmd.emit, !out_valid || !out_stall, "result overwritten")
  // A push on an empty stack always lands.
  `IPSM_ASSERT_NEXT(a_push_lands, cmd.push && stat.count_zero, !stat.count_zero, "push lost")
  // Errors are reported only on the final evaluation result.
  `IPSM_ASSERT_SAME(a_err_on_last, out_valid && status != ERR_OK, out_last && out_char == 8'd0, "error on non-final result")

endmodule
